/* sv/lik_pkg.sv */
`timescale 1ns / 1ps
package lik_pkg;

    // Shared datapath widths.
    localparam int DATA_W      = 40;   // CORDIC vector components
    localparam int ANG_W       = 32;   // Q16.16 degrees
    localparam int FRAC_W      = 16;
    localparam int CORDIC_STEPS = 17;
    localparam int STEP_W      = 5;
    localparam int RAD_W       = 31;   // square root radicand before the Q32 scale
    localparam int ROOT_W      = 32;
    localparam int MUL_W       = 19;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int PULSE_W     = 13;
    localparam int ADDR_W      = 4;

    localparam logic signed [ANG_W-1:0] DEG180_Q = 32'sd11796480;
    localparam logic signed [ANG_W-1:0] DEG90_Q  = 32'sd5898240;

    // Leg geometry and scaling constants.
    localparam logic signed [9:0]  LEG_Z0    = 10'sd88;
    localparam logic signed [9:0]  LINK_KNEE = 10'sd69;
    localparam logic signed [9:0]  REACH     = 10'sd121;
    localparam logic signed [MUL_W-1:0] P2_BIAS  = 19'sd2983;
    localparam logic signed [MUL_W-1:0] P3_BIAS  = 19'sd12505;
    localparam logic signed [MUL_W-1:0] N2_SCALE = 19'sd19044;
    localparam logic signed [PROD_W-1:0] N3_SQ   = 38'sd147476736;
    localparam logic signed [MUL_W-1:0] RECIP9   = 19'sd116509;
    localparam int RECIP_SHIFT = 20;

    typedef enum logic [1:0] {
        REG_MIRROR = 2'd0,
        REG_CAL0   = 2'd1,
        REG_CAL1   = 2'd2,
        REG_CAL2   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [7:0] target_x;
        logic signed [7:0] target_y;
        logic signed [7:0] target_z;
    } t_in_item;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_0;
        logic [PULSE_W-1:0] pulse_1;
        logic [PULSE_W-1:0] pulse_2;
        logic               out_of_reach;
    } t_out_item;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
    } t_cor_req;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [ANG_W-1:0] angle;
    } t_cor_rsp;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } t_sq_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sq_rsp;

    // Elementary CORDIC angles atan(2^-i) in Q16.16 degrees.
    function automatic logic signed [ANG_W-1:0] atan_q(input logic [STEP_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            5'd0:    v = 32'sd2949120;
            5'd1:    v = 32'sd1740967;
            5'd2:    v = 32'sd919879;
            5'd3:    v = 32'sd466945;
            5'd4:    v = 32'sd234379;
            5'd5:    v = 32'sd117304;
            5'd6:    v = 32'sd58666;
            5'd7:    v = 32'sd29335;
            5'd8:    v = 32'sd14668;
            5'd9:    v = 32'sd7334;
            5'd10:   v = 32'sd3667;
            5'd11:   v = 32'sd1833;
            5'd12:   v = 32'sd917;
            5'd13:   v = 32'sd458;
            5'd14:   v = 32'sd229;
            5'd15:   v = 32'sd115;
            5'd16:   v = 32'sd57;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q16.16 degrees truncated toward zero, saturated to -128..127.
    function automatic logic signed [7:0] deg_trunc_sat(input logic signed [ANG_W-1:0] q);
        logic [ANG_W-1:0]  mag;
        logic [15:0]       d;
        logic signed [8:0] t;
        logic signed [7:0] res;
        mag = q[ANG_W-1] ? ANG_W'(-q) : ANG_W'(q);
        d   = mag[ANG_W-1:FRAC_W];
        t   = $signed({1'b0, d[7:0]});
        if (q[ANG_W-1]) begin
            res = (d > 16'd128) ? -8'sd128 : 8'(-t);
        end else begin
            res = (d > 16'd127) ? 8'sd127 : 8'(t);
        end
        return res;
    endfunction

    // 27000 + 200 * s, with s the optionally mirrored, offset angle held to -90..90.
    function automatic logic [15:0] pulse_arg(input logic signed [7:0] angle,
                                              input logic signed [7:0] cal,
                                              input logic              neg);
        logic signed [9:0]  a;
        logic signed [9:0]  s;
        logic [16:0]        w;
        a = $signed({{2{angle[7]}}, angle});
        if (neg) begin
            a = -a;
        end
        s = a + $signed({{2{cal[7]}}, cal});
        if (s < -10'sd90) begin
            s = -10'sd90;
        end else if (s > 10'sd90) begin
            s = 10'sd90;
        end
        w = 17'd27000 + 17'd200 * {{7{s[9]}}, s};
        return w[15:0];
    endfunction

endpackage

/* sv/lik_cordic.sv */
`timescale 1ns / 1ps
module lik_cordic import lik_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cor_req i_req,
    output t_cor_rsp o_rsp
);

    // Vectoring CORDIC, one micro-rotation per cycle, stopping early once y is zero.
    logic                     r_busy;
    logic [STEP_W-1:0]        r_step;
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_y;
    logic signed [ANG_W-1:0]  r_acc;
    logic                     finish;
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;

    assign finish = r_busy && ((r_y == '0) || (r_step == STEP_W'(CORDIC_STEPS)));
    assign dx     = r_x >>> r_step;
    assign dy     = r_y >>> r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (finish) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            if (i_req.x[DATA_W-1]) begin
                r_x   <= -i_req.x;
                r_y   <= -i_req.y;
                r_acc <= i_req.y[DATA_W-1] ? -DEG180_Q : DEG180_Q;
            end else begin
                r_x   <= i_req.x;
                r_y   <= i_req.y;
                r_acc <= '0;
            end
        end else if (r_busy && !finish) begin
            if (!r_y[DATA_W-1]) begin
                r_x   <= r_x + dy;
                r_y   <= r_y - dx;
                r_acc <= r_acc + atan_q(r_step);
            end else begin
                r_x   <= r_x - dy;
                r_y   <= r_y + dx;
                r_acc <= r_acc - atan_q(r_step);
            end
        end
    end

    assign o_rsp.busy  = r_busy;
    assign o_rsp.done  = finish;
    assign o_rsp.angle = r_acc;

endmodule

/* sv/lik_isqrt.sv */
`timescale 1ns / 1ps
module lik_isqrt import lik_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_sq_req i_req,
    output t_sq_rsp o_rsp
);

    // Restoring square root of radicand * 2^32, one root bit per cycle.
    localparam int N_W   = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 1;
    localparam int CNT_W = $clog2(ROOT_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [N_W-1:0]     r_n;
    logic [REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    logic               take;

    assign rem_sh = {r_rem, r_n[N_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_n    <= {{(N_W-RAD_W-ROOT_W){1'b0}}, i_req.radicand, {ROOT_W{1'b0}}};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n <= {r_n[N_W-3:0], 2'b00};
            if (take) begin
                r_rem  <= REM_W'(rem_sh - trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

/* sv/leg_inverse_kinematics_servo.sv */
`timescale 1ns / 1ps
// A result follows the input transfer after up to four CORDIC runs (one micro-rotation
// per cycle, at most 17 each) and up to two square roots (one root bit per cycle), all
// on shared units. A new item is taken only once the previous one is solved, even while
// its result still waits in the output register.
// Reset (synchronous, active low) clears the configuration and the stored angles to zero.
module leg_inverse_kinematics_servo import lik_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Target input channel.
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    // Pulse result channel.
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // One-hot sequencer. Each *_GO state starts a shared unit, the matching *_WT
    // state waits for it. The multiplier is a single registered 19x19 product whose
    // operands are chosen by the state; its result is read in the following state.
    typedef enum logic [25:0] {
        S_IDLE   = 26'd1 << 0,
        S_HIP_GO = 26'd1 << 1,
        S_HIP_WT = 26'd1 << 2,
        S_SQ1    = 26'd1 << 3,
        S_SQ2    = 26'd1 << 4,
        S_SQ3    = 26'd1 << 5,
        S_P2SQ   = 26'd1 << 6,
        S_N2Q    = 26'd1 << 7,
        S_KCHK   = 26'd1 << 8,
        S_KA_GO  = 26'd1 << 9,
        S_KA_WT  = 26'd1 << 10,
        S_KS_GO  = 26'd1 << 11,
        S_KS_WT  = 26'd1 << 12,
        S_KC_GO  = 26'd1 << 13,
        S_KC_WT  = 26'd1 << 14,
        S_P3SQ   = 26'd1 << 15,
        S_ACHK   = 26'd1 << 16,
        S_AS_GO  = 26'd1 << 17,
        S_AS_WT  = 26'd1 << 18,
        S_AC_GO  = 26'd1 << 19,
        S_AC_WT  = 26'd1 << 20,
        S_DECIDE = 26'd1 << 21,
        S_PUL0   = 26'd1 << 22,
        S_PUL1   = 26'd1 << 23,
        S_PUL2   = 26'd1 << 24,
        S_FIN    = 26'd1 << 25
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic              r_mirror;
    logic signed [7:0] r_cal0, r_cal1, r_cal2;

    // Stored angles used when a target is out of reach.
    logic signed [7:0] r_prev_knee, r_prev_ankle;

    // Working registers of one item.
    logic signed [8:0]        r_xm, r_ym;
    logic signed [7:0]        r_z;
    logic [16:0]              r_lsq;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_t;
    logic [RAD_W-1:0]         r_d;
    logic signed [ANG_W-1:0]  r_b;
    logic [ROOT_W-1:0]        r_root;
    logic signed [7:0]        r_hip, r_knee, r_ankle;
    logic signed [7:0]        r_sa, r_sk;
    logic                     r_rej;
    logic [PULSE_W-1:0]       r_p0, r_p1;

    // Output register.
    logic      r_ovalid;
    t_out_item r_out;

    t_cor_req cor_req;
    t_cor_rsp cor_rsp;
    t_sq_req  sq_req;
    t_sq_rsp  sq_rsp;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [9:0]        l1, l2, al2, nx, rx;
    logic signed [MUL_W-1:0]  p2, p3;
    logic signed [PROD_W-1:0] kdiff, adiff;
    logic signed [ANG_W-1:0]  knee_sum;
    logic                     reject;
    logic                     in_xfer, out_load, cfg_wr;
    logic [15:0]              v0, v1, v2;
    t_reg_idx                 reg_idx;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_load = (r_state == S_FIN) && (!r_ovalid || i_out_ready);

    // Leg geometry terms derived from the latched target.
    assign l1  = LEG_Z0 - $signed({{2{r_z[7]}}, r_z});
    assign l2  = LINK_KNEE - $signed({r_ym[8], r_ym});
    assign al2 = l2[9] ? -l2 : l2;
    assign nx  = -$signed({r_xm[8], r_xm});
    assign rx  = REACH - $signed({r_ym[8], r_ym});
    assign p2  = $signed({2'b00, r_lsq}) - P2_BIAS;
    assign p3  = P3_BIAS - $signed({2'b00, r_lsq});

    // The reach tests: the cosine is valid when q^2 - p^2 is not negative.
    assign kdiff = r_prod - r_t;
    assign adiff = N3_SQ - r_prod;

    assign knee_sum = r_b + cor_rsp.angle - DEG90_Q;

    assign reject = (r_ankle == '0) && (r_knee == '0) && ((r_ym > 9'sd10) || (r_z < -8'sd10));

    // Servo 0 and 1 follow the mirror; the hip servo never does.
    assign v0 = pulse_arg(r_sa, r_cal0, r_mirror);
    assign v1 = pulse_arg(r_sk, r_cal1, r_mirror);
    assign v2 = pulse_arg(r_hip, r_cal2, 1'b0);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQ1: begin
                mul_a = MUL_W'(l1);
                mul_b = MUL_W'(l1);
            end
            S_SQ2: begin
                mul_a = MUL_W'(l2);
                mul_b = MUL_W'(l2);
            end
            S_P2SQ: begin
                mul_a = p2;
                mul_b = p2;
            end
            S_N2Q: begin
                mul_a = N2_SCALE;
                mul_b = $signed({2'b00, r_lsq});
            end
            S_P3SQ: begin
                mul_a = p3;
                mul_b = p3;
            end
            S_PUL0: begin
                mul_a = $signed({3'b000, v0});
                mul_b = RECIP9;
            end
            S_PUL1: begin
                mul_a = $signed({3'b000, v1});
                mul_b = RECIP9;
            end
            S_PUL2, S_FIN: begin
                mul_a = $signed({3'b000, v2});
                mul_b = RECIP9;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Requests to the CORDIC: hip, knee base angle, and the two arc cosines.
    always_comb begin
        cor_req.start = (r_state == S_HIP_GO) || (r_state == S_KA_GO) ||
                        (r_state == S_KC_GO) || (r_state == S_AC_GO);
        unique case (r_state)
            S_HIP_GO: begin
                cor_req.x = {{(DATA_W-26){rx[9]}}, rx, {FRAC_W{1'b0}}};
                cor_req.y = {{(DATA_W-26){nx[9]}}, nx, {FRAC_W{1'b0}}};
            end
            S_KA_GO: begin
                cor_req.x = {{(DATA_W-26){l1[9]}}, l1, {FRAC_W{1'b0}}};
                cor_req.y = {{(DATA_W-26){al2[9]}}, al2, {FRAC_W{1'b0}}};
            end
            S_KC_GO: begin
                cor_req.x = {{(DATA_W-35){p2[MUL_W-1]}}, p2, {FRAC_W{1'b0}}};
                cor_req.y = {{(DATA_W-ROOT_W){1'b0}}, r_root};
            end
            S_AC_GO: begin
                cor_req.x = {{(DATA_W-35){p3[MUL_W-1]}}, p3, {FRAC_W{1'b0}}};
                cor_req.y = {{(DATA_W-ROOT_W){1'b0}}, r_root};
            end
            default: begin
                cor_req.x = '0;
                cor_req.y = '0;
            end
        endcase
    end

    assign sq_req.start    = (r_state == S_KS_GO) || (r_state == S_AS_GO);
    assign sq_req.radicand = r_d;

    lik_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_rsp   (cor_rsp)
    );

    lik_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_rsp   (sq_rsp)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_xfer) begin
                n_state = S_HIP_GO;
            end
            S_HIP_GO: n_state = S_HIP_WT;
            S_HIP_WT: if (cor_rsp.done) begin
                n_state = S_SQ1;
            end
            S_SQ1:    n_state = S_SQ2;
            S_SQ2:    n_state = S_SQ3;
            S_SQ3:    n_state = S_P2SQ;
            S_P2SQ:   n_state = S_N2Q;
            S_N2Q:    n_state = S_KCHK;
            S_KCHK:   n_state = kdiff[PROD_W-1] ? S_P3SQ : S_KA_GO;
            S_KA_GO:  n_state = S_KA_WT;
            S_KA_WT:  if (cor_rsp.done) begin
                n_state = S_KS_GO;
            end
            S_KS_GO:  n_state = S_KS_WT;
            S_KS_WT:  if (sq_rsp.done) begin
                n_state = S_KC_GO;
            end
            S_KC_GO:  n_state = S_KC_WT;
            S_KC_WT:  if (cor_rsp.done) begin
                n_state = S_P3SQ;
            end
            S_P3SQ:   n_state = S_ACHK;
            S_ACHK:   n_state = adiff[PROD_W-1] ? S_DECIDE : S_AS_GO;
            S_AS_GO:  n_state = S_AS_WT;
            S_AS_WT:  if (sq_rsp.done) begin
                n_state = S_AC_GO;
            end
            S_AC_GO:  n_state = S_AC_WT;
            S_AC_WT:  if (cor_rsp.done) begin
                n_state = S_DECIDE;
            end
            S_DECIDE: n_state = S_PUL0;
            S_PUL0:   n_state = S_PUL1;
            S_PUL1:   n_state = S_PUL2;
            S_PUL2:   n_state = S_FIN;
            S_FIN:    if (out_load) begin
                n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Control state: sequencer, output valid, configuration and stored angles.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ovalid     <= 1'b0;
            r_mirror     <= 1'b0;
            r_cal0       <= '0;
            r_cal1       <= '0;
            r_cal2       <= '0;
            r_prev_knee  <= '0;
            r_prev_ankle <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (reg_idx)
                    REG_MIRROR: r_mirror <= pwdata[0];
                    REG_CAL0:   r_cal0   <= pwdata[7:0];
                    REG_CAL1:   r_cal1   <= pwdata[7:0];
                    REG_CAL2:   r_cal2   <= pwdata[7:0];
                    default:    r_mirror <= r_mirror;
                endcase
            end
            // A reachable target replaces the stored angles; a rejected one keeps them.
            if ((r_state == S_DECIDE) && !reject) begin
                r_prev_knee  <= r_knee;
                r_prev_ankle <= r_ankle;
            end
        end
    end

    // Datapath registers; they carry no reset because the sequencer loads them first.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (in_xfer) begin
            // The right leg solves the mirrored target; -(-128) keeps its full value.
            if (r_mirror) begin
                r_xm <= -$signed({i_in_data.target_x[7], i_in_data.target_x});
                r_ym <= -$signed({i_in_data.target_y[7], i_in_data.target_y});
            end else begin
                r_xm <= $signed({i_in_data.target_x[7], i_in_data.target_x});
                r_ym <= $signed({i_in_data.target_y[7], i_in_data.target_y});
            end
            r_z <= i_in_data.target_z;
        end
        unique case (r_state)
            S_HIP_WT: if (cor_rsp.done) begin
                r_hip <= deg_trunc_sat(cor_rsp.angle);
            end
            S_SQ2:    r_lsq <= r_prod[16:0];
            S_SQ3:    r_lsq <= r_lsq + r_prod[16:0];
            S_N2Q:    r_t <= r_prod;
            S_KCHK: begin
                r_d    <= kdiff[RAD_W-1:0];
                r_knee <= '0;
            end
            S_KA_WT:  if (cor_rsp.done) begin
                r_b <= cor_rsp.angle;
            end
            S_KS_WT:  if (sq_rsp.done) begin
                r_root <= sq_rsp.root;
            end
            S_KC_WT:  if (cor_rsp.done) begin
                r_knee <= deg_trunc_sat(knee_sum);
            end
            S_ACHK: begin
                r_d     <= adiff[RAD_W-1:0];
                r_ankle <= '0;
            end
            S_AS_WT:  if (sq_rsp.done) begin
                r_root <= sq_rsp.root;
            end
            S_AC_WT:  if (cor_rsp.done) begin
                r_ankle <= deg_trunc_sat(cor_rsp.angle - DEG90_Q);
            end
            S_DECIDE: begin
                r_rej <= reject;
                r_sa  <= reject ? r_prev_ankle : r_ankle;
                r_sk  <= reject ? r_prev_knee : r_knee;
            end
            S_PUL1:   r_p0 <= r_prod[RECIP_SHIFT+PULSE_W-1:RECIP_SHIFT];
            S_PUL2:   r_p1 <= r_prod[RECIP_SHIFT+PULSE_W-1:RECIP_SHIFT];
            default:  r_b <= r_b;
        endcase
        if (out_load) begin
            r_out.pulse_0      <= r_p0;
            r_out.pulse_1      <= r_p1;
            r_out.pulse_2      <= r_prod[RECIP_SHIFT+PULSE_W-1:RECIP_SHIFT];
            r_out.out_of_reach <= r_rej;
        end
    end

    // Configuration port: one register per word, read back zero-extended.
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready  = 1'b1;

    always_comb begin
        unique case (reg_idx)
            REG_MIRROR: prdata = {31'd0, r_mirror};
            REG_CAL0:   prdata = {24'd0, r_cal0};
            REG_CAL1:   prdata = {24'd0, r_cal1};
            REG_CAL2:   prdata = {24'd0, r_cal2};
            default:    prdata = '0;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // The CORDIC and the square root are never busy at the same time.
    a_units_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cor_rsp.busy && sq_rsp.busy))
        else $error("CORDIC and square root unit busy together");

    // A unit is only started while it is idle.
    a_cor_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_req.start |-> !cor_rsp.busy)
        else $error("CORDIC started while busy");

    a_sq_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_req.start |-> !sq_rsp.busy)
        else $error("square root started while busy");

    // Every loaded result holds pulses inside the servo range.
    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid &&
            o_out_data.pulse_0 >= 13'd1000 && o_out_data.pulse_0 <= 13'd5000 &&
            o_out_data.pulse_1 >= 13'd1000 && o_out_data.pulse_1 <= 13'd5000 &&
            o_out_data.pulse_2 >= 13'd1000 && o_out_data.pulse_2 <= 13'd5000))
        else $error("pulse value out of servo range");

    // After an input transfer the block is busy solving it.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_in_ready)
        else $error("input taken again right after a transfer");

endmodule
